// ----- src/dtp_pkg.sv -----
// shared constants and types for the duration text parser
`timescale 1ns / 1ps
`default_nettype none
package dtp_pkg;

  localparam int UNIT_CHARS_DEF = 12;
  localparam int CHAR_W = 8;
  localparam int SEC_W = 64;
  localparam int NS_W = 31;
  localparam int CODE_W = 4;
  localparam int OUT_W = ((SEC_W + NS_W + CODE_W + 7) / 8) * 8;

  typedef enum logic [CODE_W-1:0] {
    UNIT_SEC     = 4'd0,
    UNIT_MS      = 4'd1,
    UNIT_US      = 4'd2,
    UNIT_NS      = 4'd3,
    UNIT_MIN     = 4'd4,
    UNIT_HOUR    = 4'd5,
    UNIT_DAY     = 4'd6,
    UNIT_WEEK    = 4'd7,
    UNIT_UNKNOWN = 4'd8
  } unit_code_t;

  function automatic int len_width(input int chars);
    return $clog2(chars + 1);
  endfunction

  function automatic int job_width(input int chars);
    return 1 + len_width(chars) + chars * CHAR_W + 1 + SEC_W;
  endfunction

endpackage
`default_nettype wire

// ----- src/dtp_queue.sv -----
// two entry queue between the parser front and the scaling back
`timescale 1ns / 1ps
`default_nettype none
module dtp_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
`endif
endmodule
`default_nettype wire

// ----- src/dtp_front.sv -----
// character parser: sign, radix, digits and unit letters, one beat per cycle while the queue is not full
`timescale 1ns / 1ps
`default_nettype none
module dtp_front #(
  parameter int UNIT_CHARS = dtp_pkg::UNIT_CHARS_DEF,
  parameter int JOB_W = dtp_pkg::job_width(dtp_pkg::UNIT_CHARS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,
  input  wire logic             s_tuser,
  input  wire logic             s_tlast,
  input  wire logic             full,
  output logic                  push,
  output logic [JOB_W-1:0]      job
);
  import dtp_pkg::*;

  localparam int LEN_W = len_width(UNIT_CHARS);
  localparam int IDX_W = $clog2(UNIT_CHARS);

  typedef enum logic [2:0] {
    PH_SIGN, PH_ZERO, PH_NUM, PH_SPACE, PH_UNIT, PH_DONE
  } phase_t;
  typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_OCT} radix_t;

  phase_t                          phase, phase_next;
  logic [SEC_W-1:0]                accumulator, accumulator_next;
  logic                            negative, negative_next;
  radix_t                          radix_mode, radix_mode_next;
  logic [UNIT_CHARS-1:0][7:0]      unit_letters, unit_letters_next;
  logic [LEN_W-1:0]                unit_length, unit_length_next;
  logic                            unit_too_long, unit_too_long_next;
  logic                            beat;

  assign s_tready = ~full;
  assign beat = s_tvalid & s_tready;
  assign push = beat & s_tlast;
  assign job = {unit_too_long_next, unit_length_next, unit_letters_next,
                negative_next, accumulator_next};

  always_comb begin
    logic       go;
    logic [7:0] c;
    logic       is_dig;
    logic [3:0] dig;
    logic       letter;
    phase_next = phase;
    accumulator_next = accumulator;
    negative_next = negative;
    radix_mode_next = radix_mode;
    unit_letters_next = unit_letters;
    unit_length_next = unit_length;
    unit_too_long_next = unit_too_long;
    c = s_tdata;
    go = s_tuser;
    letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    if (s_tuser && c == 8'd0) begin
      phase_next = PH_DONE;
      go = 1'b0;
    end
    if (go && phase_next == PH_SIGN) begin
      go = 1'b0;
      if (c == "-") begin
        negative_next = ~negative;
      end else if (c == "0") begin
        phase_next = PH_ZERO;
      end else if (c == "\\") begin
        phase_next = PH_NUM;
        radix_mode_next = RADIX_OCT;
      end else if (c >= "1" && c <= "9") begin
        phase_next = PH_NUM;
        radix_mode_next = RADIX_DEC;
        accumulator_next = {{(SEC_W-4){1'b0}}, c[3:0]};
      end else begin
        phase_next = PH_SPACE;
        go = 1'b1;
      end
    end
    if (go && phase_next == PH_ZERO) begin
      phase_next = PH_NUM;
      if (c == "x") begin
        radix_mode_next = RADIX_HEX;
        go = 1'b0;
      end else begin
        radix_mode_next = RADIX_DEC;
      end
    end
    if (go && phase_next == PH_NUM) begin
      is_dig = 1'b0;
      dig = 4'd0;
      case (radix_mode_next)
        RADIX_HEX: begin
          if (c >= "0" && c <= "9") begin
            is_dig = 1'b1;
            dig = c[3:0];
          end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            is_dig = 1'b1;
            dig = c[3:0] + 4'd9;
          end
        end
        RADIX_OCT: begin
          is_dig = (c >= "0" && c <= "7");
          dig = c[3:0];
        end
        default: begin
          is_dig = (c >= "0" && c <= "9");
          dig = c[3:0];
        end
      endcase
      if (is_dig) begin
        go = 1'b0;
        case (radix_mode_next)
          RADIX_HEX: accumulator_next = (accumulator_next << 4) + {{(SEC_W-4){1'b0}}, dig};
          RADIX_OCT: accumulator_next = (accumulator_next << 3) + {{(SEC_W-4){1'b0}}, dig};
          default: accumulator_next = (accumulator_next << 3) + (accumulator_next << 1)
                                      + {{(SEC_W-4){1'b0}}, dig};
        endcase
      end else begin
        phase_next = PH_SPACE;
      end
    end
    if (go && phase_next == PH_SPACE) begin
      if (c == " " || c == 8'd13 || c == 8'd10 || c == 8'd9) begin
        go = 1'b0;
      end else if (letter) begin
        phase_next = PH_UNIT;
      end else begin
        phase_next = PH_DONE;
        go = 1'b0;
      end
    end
    if (go && phase_next == PH_UNIT) begin
      if (letter) begin
        if (unit_length < LEN_W'(UNIT_CHARS)) begin
          unit_letters_next[unit_length[IDX_W-1:0]] = c | 8'h20;
          unit_length_next = unit_length + LEN_W'(1);
        end else begin
          unit_too_long_next = 1'b1;
        end
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      unit_letters <= unit_letters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase <= PH_SIGN;
      accumulator <= '0;
      negative <= 1'b0;
      radix_mode <= RADIX_DEC;
      unit_length <= '0;
      unit_too_long <= 1'b0;
    end else if (beat) begin
      phase <= phase_next;
      accumulator <= accumulator_next;
      negative <= negative_next;
      radix_mode <= radix_mode_next;
      unit_length <= unit_length_next;
      unit_too_long <= unit_too_long_next;
    end
  end

`ifndef SYNTH
  a_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (phase == PH_SIGN && unit_length == '0 && accumulator == '0))
    else $error("parser did not restart after end of text");
`endif
endmodule
`default_nettype wire

// ----- src/dtp_back.sv -----
// unit decode and scaling of one parsed value
`timescale 1ns / 1ps
`default_nettype none
module dtp_back #(
  parameter int UNIT_CHARS = dtp_pkg::UNIT_CHARS_DEF,
  parameter int JOB_W = dtp_pkg::job_width(dtp_pkg::UNIT_CHARS_DEF)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    head_valid,
  input  wire logic [JOB_W-1:0]        head_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [dtp_pkg::OUT_W-1:0]    m_tdata
);
  import dtp_pkg::*;

  localparam int LEN_W = len_width(UNIT_CHARS);

  // floor(2^64 / divisor), the estimate is low by at most one
  localparam logic [SEC_W-1:0] RECIP_MS = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;
  localparam logic [SEC_W-1:0] RECIP_US = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000;
  localparam logic [SEC_W-1:0] RECIP_NS = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000000;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_REM, S_FIX, S_NS, S_MUL, S_OUT} state_t;

  state_t                     state;
  logic [SEC_W-1:0]           j_acc;
  logic                       j_neg;
  logic [UNIT_CHARS-1:0][7:0] j_letters;
  logic [LEN_W-1:0]           j_len;
  logic                       j_long;
  unit_code_t                 code_in;
  logic [SEC_W-1:0]           u_in;

  logic [SEC_W-1:0]           work;
  logic [SEC_W-1:0]           prod;
  logic [SEC_W-1:0]           recip;
  logic [2*SEC_W-1:0]         wide;
  logic [29:0]                rem;
  logic [30:0]                rem_est;
  logic [29:0]                divisor;
  logic [19:0]                scale;
  logic                       sign;
  logic [5:0]                 cnt;
  logic [SEC_W-1:0]           sec;
  logic [NS_W-1:0]            nsec;
  unit_code_t                 code;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [63:0]                mul_p;
  logic [31:0]                low_diff;
  logic [49:0]                ns_prod;

  assign {j_long, j_len, j_letters, j_neg, j_acc} = head_data;
  assign u_in = j_neg ? (~j_acc + SEC_W'(1)) : j_acc;
  assign pop = (state == S_IDLE) && head_valid;
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {{(OUT_W-SEC_W-NS_W-CODE_W){1'b0}}, code, nsec, sec};
  assign ns_prod = rem * scale;

  // shared 32 by 32 multiplier: partial products, then quotient times divisor
  always_comb begin
    if (state == S_REM) begin
      mul_a = wide[95:64];
      mul_b = {2'b00, divisor};
    end else begin
      mul_a = cnt[1] ? work[63:32] : work[31:0];
      mul_b = cnt[0] ? recip[63:32] : recip[31:0];
    end
  end
  assign mul_p = mul_a * mul_b;
  assign low_diff = work[31:0] - mul_p[31:0];

  function automatic logic name_is(input logic [95:0] nm, input int n);
    logic ok;
    ok = (j_len == LEN_W'(n));
    for (int i = 0; i < 12; i++) begin
      if (i < n && j_letters[i] != nm[8*(n-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    if (j_long) code_in = UNIT_UNKNOWN;
    else if (j_len == '0 || name_is("s", 1) || name_is("sec", 3)
             || name_is("second", 6) || name_is("seconds", 7)) code_in = UNIT_SEC;
    else if (name_is("ms", 2) || name_is("millisecond", 11)
             || name_is("milliseconds", 12)) code_in = UNIT_MS;
    else if (name_is("us", 2) || name_is("microsecond", 11)
             || name_is("microseconds", 12)) code_in = UNIT_US;
    else if (name_is("ns", 2) || name_is("nanosecond", 10)
             || name_is("nanoseconds", 11)) code_in = UNIT_NS;
    else if (name_is("m", 1) || name_is("minute", 6) || name_is("minutes", 7))
      code_in = UNIT_MIN;
    else if (name_is("h", 1) || name_is("hour", 4) || name_is("hours", 5))
      code_in = UNIT_HOUR;
    else if (name_is("d", 1) || name_is("day", 3) || name_is("days", 4))
      code_in = UNIT_DAY;
    else if (name_is("w", 1) || name_is("week", 4) || name_is("weeks", 5))
      code_in = UNIT_WEEK;
    else code_in = UNIT_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            code <= code_in;
            sign <= u_in[SEC_W-1];
            rem <= '0;
            prod <= '0;
            nsec <= '0;
            unique case (code_in)
              UNIT_MS, UNIT_US, UNIT_NS: begin
                work <= u_in[SEC_W-1] ? (~u_in + SEC_W'(1)) : u_in;
                cnt <= 6'd0;
                state <= S_DIV;
                unique case (code_in)
                  UNIT_MS: begin
                    divisor <= 30'd1000; scale <= 20'd1000000; recip <= RECIP_MS;
                  end
                  UNIT_US: begin
                    divisor <= 30'd1000000; scale <= 20'd1000; recip <= RECIP_US;
                  end
                  default: begin
                    divisor <= 30'd1000000000; scale <= 20'd1; recip <= RECIP_NS;
                  end
                endcase
              end
              UNIT_MIN, UNIT_HOUR, UNIT_DAY, UNIT_WEEK: begin
                work <= u_in;
                cnt <= 6'd19;
                state <= S_MUL;
                unique case (code_in)
                  UNIT_MIN:  scale <= 20'd60;
                  UNIT_HOUR: scale <= 20'd3600;
                  UNIT_DAY:  scale <= 20'd86400;
                  default:   scale <= 20'd604800;
                endcase
              end
              default: begin
                sec <= u_in;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          case (cnt[1:0])
            2'd0: wide <= {64'd0, mul_p};
            2'd3: wide <= wide + {mul_p, 64'd0};
            default: wide <= wide + {32'd0, mul_p, 32'd0};
          endcase
          cnt <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) state <= S_REM;
        end
        S_REM: begin
          work <= wide[127:64];
          rem_est <= low_diff[30:0];
          state <= S_FIX;
        end
        S_FIX: begin
          if (rem_est >= {1'b0, divisor}) begin
            work <= work + SEC_W'(1);
            rem <= 30'(rem_est - {1'b0, divisor});
          end else begin
            rem <= rem_est[29:0];
          end
          state <= S_NS;
        end
        S_NS: begin
          sec <= sign ? (~work + SEC_W'(1)) : work;
          nsec <= sign ? (~{1'b0, ns_prod[29:0]} + NS_W'(1)) : {1'b0, ns_prod[29:0]};
          state <= S_OUT;
        end
        S_MUL: begin
          if (scale[0]) prod <= prod + work;
          work <= work << 1;
          scale <= scale >> 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            sec <= scale[0] ? prod + work : prod;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt[1:0] == 2'd3) |=> state == S_REM)
    else $error("division did not finish after all partial products");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ----- src/duration_text_parse.sv -----
// top level of the streaming duration text parser
// Input stream: one text character per beat. s_tdata[7:0] is the character,
// s_tuser is 1 when the beat carries a character, s_tlast ends the text.
// Output stream: one result beat per text, m_tdata holds seconds [63:0],
// nanoseconds [94:64] (signed) and unit code [98:95], upper bits zero.
// The parser front takes one character per cycle; s_tready drops only
// when the two entry queue of finished texts is full.
// The back decodes the unit name and scales the value: ms, us and ns use a
// reciprocal multiply built from partial products on one 32 by 32 multiplier,
// then remainder, correction and nanosecond states; minute, hour, day and
// week use shift and add over the 20-bit scale; seconds need no scaling.
// The back works on one text at a time and pops the next only when idle.
// A stalled m_tready holds the result; later texts still enter until the
// queue fills. Synchronous reset rst clears the parser, queue and back
// and drops any text in progress.
`timescale 1ns / 1ps
`default_nettype none
module duration_text_parse #(
  parameter int UNIT_CHARS = dtp_pkg::UNIT_CHARS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // char_code
  input  wire logic                  s_tuser,   // char_valid
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [dtp_pkg::OUT_W-1:0]  m_tdata    // seconds, nanoseconds, unit_code
);
  import dtp_pkg::*;

  localparam int JOB_W = job_width(UNIT_CHARS);

  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  logic [JOB_W-1:0] job;
  logic [JOB_W-1:0] head_data;

  dtp_front #(.UNIT_CHARS(UNIT_CHARS), .JOB_W(JOB_W)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .full(full), .push(push), .job(job)
  );

  dtp_queue #(.WIDTH(JOB_W)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(job), .full(full),
    .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  dtp_back #(.UNIT_CHARS(UNIT_CHARS), .JOB_W(JOB_W)) u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head_data(head_data), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );
endmodule
`default_nettype wire

// ----- dv/duration_text_parse_tb.sv -----
// self-checking testbench for the streaming duration text parser
`timescale 1ns / 1ps
`default_nettype none
module duration_text_parse_tb;
  import dtp_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  typedef enum int {PH_SIGN, PH_ZERO, PH_NUM, PH_SPACE, PH_UNIT, PH_DONE} parse_ph_t;
  typedef enum int {RX_DEC, RX_HEX, RX_OCT} radix_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0] nsec;
    unit_code_t code;
  } dur_t;

  class dur_scoreboard;
    parse_ph_t ph;
    logic [63:0] acc;
    bit neg;
    radix_t rx;
    byte unsigned letters[12];
    int ulen;
    bit toolong;
    dur_t pending[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_SIGN; acc = 0; neg = 0; rx = RX_DEC; ulen = 0; toolong = 0;
      foreach (letters[i]) letters[i] = 0;
    endfunction

    function int digit(byte unsigned c);
      if (rx == RX_HEX) begin
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
      end
      if (rx == RX_OCT) return (c >= "0" && c <= "7") ? c - "0" : -1;
      return (c >= "0" && c <= "9") ? c - "0" : -1;
    endfunction

    function bit is_letter(byte unsigned c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function void take(byte unsigned c);
      bit again;
      int d;
      again = 1;
      if (c == 0) begin
        ph = PH_DONE;
        return;
      end
      while (again) begin
        again = 0;
        case (ph)
          PH_SIGN: begin
            if (c == "-") neg ^= 1;
            else if (c == "0") ph = PH_ZERO;
            else if (c == 8'h5c) begin ph = PH_NUM; rx = RX_OCT; end
            else if (c >= "1" && c <= "9") begin
              ph = PH_NUM; rx = RX_DEC; acc = c - "0";
            end else begin ph = PH_SPACE; again = 1; end
          end
          PH_ZERO: begin
            ph = PH_NUM;
            if (c == "x") rx = RX_HEX;
            else begin rx = RX_DEC; again = 1; end
          end
          PH_NUM: begin
            d = digit(c);
            if (d < 0) begin ph = PH_SPACE; again = 1; end
            else if (rx == RX_HEX) acc = (acc << 4) + d;
            else if (rx == RX_OCT) acc = (acc << 3) + d;
            else acc = acc * 10 + d;
          end
          PH_SPACE: begin
            if (c == " " || c == 8'h0d || c == 8'h0a || c == 8'h09) ;
            else if (is_letter(c)) begin ph = PH_UNIT; again = 1; end
            else ph = PH_DONE;
          end
          PH_UNIT: begin
            if (is_letter(c)) begin
              if (ulen < 12) begin
                letters[ulen] = (c >= "A" && c <= "Z") ? c + 32 : c;
                ulen++;
              end else toolong = 1;
            end else ph = PH_DONE;
          end
          default: ;
        endcase
      end
    endfunction

    function bit unit_is(string s);
      if (s.len() != ulen) return 0;
      for (int i = 0; i < ulen; i++) if (letters[i] != s[i]) return 0;
      return 1;
    endfunction

    function bit any3(string a, string b, string c);
      return unit_is(a) || unit_is(b) || unit_is(c);
    endfunction

    function unit_code_t decode();
      if (toolong) return UNIT_UNKNOWN;
      if (ulen == 0 || unit_is("s") || any3("sec", "second", "seconds")) return UNIT_SEC;
      if (any3("ms", "millisecond", "milliseconds")) return UNIT_MS;
      if (any3("us", "microsecond", "microseconds")) return UNIT_US;
      if (any3("ns", "nanosecond", "nanoseconds")) return UNIT_NS;
      if (any3("m", "minute", "minutes")) return UNIT_MIN;
      if (any3("h", "hour", "hours")) return UNIT_HOUR;
      if (any3("d", "day", "days")) return UNIT_DAY;
      if (any3("w", "week", "weeks")) return UNIT_WEEK;
      return UNIT_UNKNOWN;
    endfunction

    function void note_beat(byte unsigned c, bit cv, bit lst);
      logic [63:0] u;
      longint v, ns;
      dur_t r;
      if (cv) take(c);
      if (!lst) return;
      u = neg ? -acc : acc;
      v = u;
      ns = 0;
      r.code = decode();
      case (r.code)
        UNIT_MS: begin r.sec = v / 1000; ns = (v % 1000) * 1000000; end
        UNIT_US: begin r.sec = v / 1000000; ns = (v % 1000000) * 1000; end
        UNIT_NS: begin r.sec = v / 1000000000; ns = v % 1000000000; end
        UNIT_MIN: r.sec = u * 60;
        UNIT_HOUR: r.sec = u * 3600;
        UNIT_DAY: r.sec = u * 86400;
        UNIT_WEEK: r.sec = u * 604800;
        default: r.sec = u;
      endcase
      r.nsec = ns[NS_W-1:0];
      pending = {pending, r};
      clear();
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      dur_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.sec) begin
        $display("%0t seconds exp %h got %h", $time, e.sec, d[63:0]); errors++;
      end
      if (d[94:64] !== e.nsec) begin
        $display("%0t nanoseconds exp %h got %h", $time, e.nsec, d[94:64]); errors++;
      end
      if (d[98:95] !== e.code) begin
        $display("%0t unit exp %0d got %0d", $time, e.code, d[98:95]); errors++;
      end
      if (d[OUT_W-1:99] !== 0) begin
        $display("%0t pad exp 0 got %h", $time, d[OUT_W-1:99]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tuser = 0, s_tlast = 0, m_tready = 0;
  logic [7:0] s_tdata = 0;
  wire s_tready, m_tvalid;
  wire [OUT_W-1:0] m_tdata;
  int send_idle = 0, recv_stall = 0, quiet = 0;
  dur_scoreboard sb = new();

  duration_text_parse uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCH_LIMIT) begin
      $display("duration_text_parse test failed");
      $finish;
    end
  end

  task automatic send_beat(byte unsigned c, bit cv, bit lst);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= c; s_tuser <= cv; s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(c, cv, lst);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1, i == s.len() - 1);
    if (s.len() == 0) send_beat(0, 0, 1);
  endtask

  function automatic string pick_unit();
    string units[34] = '{"", "s", "sec", "second", "seconds", "ms", "millisecond",
      "milliseconds", "us", "microsecond", "microseconds", "ns", "nanosecond",
      "nanoseconds", "m", "minute", "minutes", "h", "hour", "hours", "d", "day",
      "days", "w", "week", "weeks", "xyz", "MS", "Hours", "secondsecondsx",
      "abcdefghijkl", "q", "Week", "NanoSecondS"};
    return units[$urandom_range(33)];
  endfunction

  function automatic string rand_text();
    string s = "", dg;
    int n, k;
    k = $urandom_range(99);
    n = $urandom_range(3);
    repeat (($urandom_range(3) == 0) ? $urandom_range(3) : 0) s = {s, "-"};
    if (k < 8) begin
      repeat ($urandom_range(6)) s = {s, string'(byte'($urandom_range(1, 255)))};
      return s;
    end
    case ($urandom_range(2))
      0: begin s = {s, "0x"}; dg = "0123456789abcdefABCDEF"; end
      1: begin s = {s, "\\"}; dg = "01234567"; end
      default: dg = "0123456789";
    endcase
    n = ($urandom_range(4) == 0) ? $urandom_range(25) : $urandom_range(6);
    repeat (n) s = {s, string'(dg[$urandom_range(dg.len() - 1)])};
    repeat ($urandom_range(2)) s = {s, ($urandom_range(1) ? " " : "\t")};
    s = {s, pick_unit()};
    if (k > 90) s = {s, string'(byte'($urandom_range(0, 255))), "ms"};
    return s;
  endfunction

  string dirs[] = '{"", "0", "-15 ms", "0x1F minutes", "\\17h", "--5", "0x", "0xAz s",
    "18446744073709551615", "99999999999999999999999", "0xffffffffffffffff us",
    "-1234567891ns", "-999 ms", "7 d", "3weeks", "2 HOUR", "abc", "12 !x",
    "5 abcdefghijklmn", "\\777", "1\015\n day", "-0x8000000000000000"};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    foreach (dirs[i]) send_text(dirs[i]);
    send_beat("4", 1, 0); send_beat("m", 0, 0); send_beat(0, 1, 0);
    send_beat("s", 1, 1);
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin send_idle = 46; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 46; end
        3: begin send_idle = 11; recv_stall = 11; end
        4: begin send_idle = 0; recv_stall = 0; end
        default: ;
      endcase
      repeat (4) send_text(rand_text());
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("duration_text_parse test passed");
    else $display("duration_text_parse test failed");
    $finish;
  end
endmodule
`default_nettype wire
